// File: rtl/tgs_pkg.sv
// ----------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the touch gesture slot machine
// Holds the item structs, phase codes, register indexes and helper functions.
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int unsigned SlotCount = 10;
  localparam int unsigned SlotW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_CAND = 5'b00010,
    PH_DRAG = 5'b00100,
    PH_LONG = 5'b01000,
    PH_REL  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    EV_IDLE = 2'd0,
    EV_DOWN = 2'd1,
    EV_MOVE = 2'd2,
    EV_UP   = 2'd3
  } event_e;

  localparam logic [2:0] RegStable  = 3'd0;
  localparam logic [2:0] RegMinSig  = 3'd1;
  localparam logic [2:0] RegMinSize = 3'd2;
  localparam logic [2:0] RegDrag    = 3'd3;
  localparam logic [2:0] RegLongFr  = 3'd4;
  localparam logic [2:0] RegLongTol = 3'd5;
  localparam logic [2:0] RegGrace   = 3'd6;

  typedef struct packed {
    logic [3:0]  slot_index;
    logic        contact_present;
    logic        tracker_up;
    logic [15:0] contact_x;
    logic [15:0] contact_y;
    logic [23:0] contact_signal;
    logic [15:0] contact_size;
    logic [11:0] contact_area;
    logic        contact_edge;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_slot;
    logic        reported;
    logic [1:0]  report_event;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [23:0] out_signal;
    logic [15:0] out_size;
    logic [11:0] out_area;
    logic        out_edge;
    logic        last_of_item;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  press_stable_frames;
    logic [23:0] press_min_signal;
    logic [15:0] press_min_size;
    logic [15:0] drag_threshold;
    logic [8:0]  long_press_frames;
    logic [15:0] long_press_tolerance;
    logic [4:0]  release_grace_frames;
  } cfg_t;

  // Item passed from front to back, with its slot trimmed to the width of
  // the slot store index.
  typedef struct packed {
    logic [SlotW-1:0] slot;
    in_item_t         item;
  } work_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

// File: rtl/tgs_front.sv
// ----------------------------------------------------------------------------
// tgs_front: input stage
// Accepts items, drops out-of-range slots and queues the rest for the back.
// ----------------------------------------------------------------------------
module tgs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  tgs_pkg::in_item_t item_i,
  output logic              wvalid_o,
  input  logic              wready_i,
  output tgs_pkg::work_t    work_o
);
  import tgs_pkg::*;

  // Two-entry queue decouples the tracker side from the slot engine.
  work_t     mem_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;
  logic      acc, keep, deq;

  assign full_o   = (cnt_q == 2'd2);
  assign acc      = push_i && !full_o;
  assign keep     = acc && ({28'd0, item_i.slot_index} < 32'(SlotCount));
  assign wvalid_o = (cnt_q != 2'd0);
  assign deq      = wvalid_o && wready_i;
  assign work_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (keep) begin
      mem_q[wr_q] <= '{slot: item_i.slot_index[SlotW-1:0], item: item_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (keep) wr_q <= ~wr_q;
      if (deq) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, keep} - {1'b0, deq};
    end
  end
endmodule

// File: rtl/tgs_back.sv
// ----------------------------------------------------------------------------
// tgs_back: slot engine
// Runs the per-slot phase machine and emits reports and up events.
// ----------------------------------------------------------------------------
module tgs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tgs_pkg::cfg_t      cfg_i,
  input  logic               wvalid_i,
  output logic               wready_o,
  input  tgs_pkg::work_t     work_i,
  output logic               empty_o,
  input  logic               pop_i,
  output tgs_pkg::out_item_t res_o
);
  import tgs_pkg::*;

  phase_e      phase_q [SlotCount];
  phase_e      prev_q  [SlotCount];
  logic [31:0] anchor_q [SlotCount];
  logic [31:0] oxy_q    [SlotCount];
  logic [15:0] age_q    [SlotCount];
  logic [15:0] miss_q   [SlotCount];
  logic [15:0] stab_q   [SlotCount];
  logic [52:0] held_q   [SlotCount];
  logic        cool_q   [SlotCount];

  // Stage 1 register: squared distances computed from current anchor.
  logic        s1_v_q;
  work_t       s1_q;
  logic [32:0] s1_d2_q;
  logic [31:0] dthr_q, ltol_q;

  // Output queue of four result entries.
  out_item_t   oq_q [4];
  logic [1:0]  owr_q, ord_q;
  logic [2:0]  ocnt_q;

  // Stage 1: look up anchor and compute distance. A hazard arises when the
  // same slot is in stage 2 this cycle; stall for that case.
  logic        haz, s2_go, fire;
  logic [15:0] dx, dy;
  logic [31:0] ax;
  logic [SlotW-1:0] ws;

  assign ws   = work_i.slot;
  assign haz  = s1_v_q && (s1_q.slot == ws);
  assign ax   = anchor_q[ws];
  assign dx   = abs_diff(work_i.item.contact_x, ax[31:16]);
  assign dy   = abs_diff(work_i.item.contact_y, ax[15:0]);
  assign s2_go    = s1_v_q && (ocnt_q <= 3'd2);
  assign wready_o = (!s1_v_q || s2_go) && !haz;
  assign fire     = wvalid_i && wready_o;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_q    <= work_i;
      s1_d2_q <= {1'b0, 32'(dx) * 32'(dx)} + {1'b0, 32'(dy) * 32'(dy)};
      dthr_q  <= 32'(cfg_i.drag_threshold) * 32'(cfg_i.drag_threshold);
      ltol_q  <= 32'(cfg_i.long_press_tolerance) * 32'(cfg_i.long_press_tolerance);
    end
  end

  // Stage 2 next-state logic.
  logic [SlotW-1:0] s;
  in_item_t it;
  logic live;
  phase_e ph, n_ph, n_prev;
  logic [31:0] xy, n_anchor, n_oxy;
  logic [15:0] n_age, n_miss, n_stab;
  logic [52:0] info, n_held;
  logic n_cool, stable, far, do_up, rep_v;
  out_item_t rep, up;

  always_comb begin
    s      = s1_q.slot;
    it     = s1_q.item;
    live   = it.contact_present && !it.tracker_up;
    ph     = phase_q[s];
    xy     = {it.contact_x, it.contact_y};
    info   = {it.contact_signal, it.contact_size, it.contact_area, it.contact_edge};
    far    = {1'b0, dthr_q} < s1_d2_q;
    n_ph = ph; n_prev = prev_q[s]; n_anchor = anchor_q[s]; n_oxy = oxy_q[s];
    n_age = age_q[s]; n_miss = miss_q[s]; n_stab = stab_q[s];
    n_held = held_q[s]; n_cool = cool_q[s];
    stable = 1'b1;
    if (ph == PH_IDLE && !live) begin
      n_cool = 1'b0;
    end else if (ph == PH_IDLE && cool_q[s]) begin
      n_cool = 1'b0;
    end else if (ph == PH_IDLE) begin
      n_ph = PH_CAND; n_anchor = xy; n_oxy = xy; n_age = 16'd1;
      n_miss = 16'd0; n_stab = 16'd1; n_held = info;
    end else if (ph == PH_REL) begin
      if (live) begin
        n_ph = prev_q[s]; n_miss = 16'd0; n_held = info;
        if (prev_q[s] == PH_DRAG) n_oxy = xy;
      end else begin
        n_miss = sat_inc(miss_q[s]);
      end
    end else if (!live) begin
      n_prev = ph; n_ph = PH_REL;
      n_miss = (ph == PH_CAND) ? 16'd1 : {11'd0, cfg_i.release_grace_frames} + 16'd1;
    end else begin
      n_age = sat_inc(age_q[s]); n_miss = 16'd0; n_held = info;
      if (ph == PH_DRAG) begin
        n_oxy = xy;
      end else if (ph == PH_LONG) begin
        if (far) begin n_ph = PH_DRAG; n_oxy = xy; end
        else n_oxy = anchor_q[s];
      end else begin
        if (cfg_i.press_min_signal != 24'd0 && it.contact_signal < cfg_i.press_min_signal)
          stable = 1'b0;
        if (cfg_i.press_min_size != 16'd0 && it.contact_size < cfg_i.press_min_size)
          stable = 1'b0;
        n_stab = stable ? sat_inc(stab_q[s]) : 16'd0;
        n_oxy  = anchor_q[s];
        if (far) begin
          n_ph = PH_DRAG; n_oxy = xy;
        end else if (n_age >= {7'd0, cfg_i.long_press_frames} &&
                     s1_d2_q <= {1'b0, ltol_q}) begin
          n_ph = PH_LONG;
        end
      end
    end

    rep = '0;
    rep.out_slot = it.slot_index;
    rep.report_event = EV_IDLE;
    {rep.out_x, rep.out_y} = xy;
    rep.out_signal = it.contact_signal; rep.out_size = it.contact_size;
    rep.out_area = it.contact_area; rep.out_edge = it.contact_edge;
    unique case (n_ph)
      PH_CAND: if (n_stab >= {11'd0, cfg_i.press_stable_frames}) begin
        rep.reported = 1'b1; rep.report_event = EV_DOWN; {rep.out_x, rep.out_y} = n_oxy;
      end
      PH_DRAG, PH_LONG, PH_REL: begin
        rep.reported = 1'b1; rep.report_event = EV_MOVE; {rep.out_x, rep.out_y} = n_oxy;
      end
      default: ;
    endcase
    rep_v = it.contact_present;
    do_up = (n_ph == PH_REL) && (n_miss > {11'd0, cfg_i.release_grace_frames});
    rep.last_of_item = !do_up;
    up = '0;
    up.out_slot = it.slot_index; up.reported = 1'b1; up.report_event = EV_UP;
    {up.out_x, up.out_y} = n_oxy;
    {up.out_signal, up.out_size, up.out_area, up.out_edge} = n_held;
    up.last_of_item = 1'b1;
  end

  logic [1:0] nres;
  assign nres = {1'b0, rep_v} + {1'b0, do_up};
  logic deq;
  assign empty_o = (ocnt_q == 3'd0);
  assign deq = pop_i && !empty_o;
  assign res_o = oq_q[ord_q];

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      if (rep_v) oq_q[owr_q] <= rep;
      if (do_up) oq_q[owr_q + {1'b0, rep_v}] <= up;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      owr_q <= '0; ord_q <= '0; ocnt_q <= '0;
      for (int i = 0; i < SlotCount; i++) begin
        phase_q[i] <= PH_IDLE; prev_q[i] <= PH_IDLE; anchor_q[i] <= '0;
        oxy_q[i] <= '0; age_q[i] <= '0; miss_q[i] <= '0; stab_q[i] <= '0;
        held_q[i] <= '0; cool_q[i] <= 1'b0;
      end
    end else begin
      if (fire) s1_v_q <= 1'b1;
      else if (s2_go) s1_v_q <= 1'b0;
      if (s2_go) begin
        owr_q <= owr_q + nres;
        if (do_up) begin
          phase_q[s] <= PH_IDLE; prev_q[s] <= PH_IDLE; anchor_q[s] <= '0;
          oxy_q[s] <= '0; age_q[s] <= '0; miss_q[s] <= '0; stab_q[s] <= '0;
          held_q[s] <= '0; cool_q[s] <= 1'b1;
        end else begin
          phase_q[s] <= n_ph; prev_q[s] <= n_prev; anchor_q[s] <= n_anchor;
          oxy_q[s] <= n_oxy; age_q[s] <= n_age; miss_q[s] <= n_miss;
          stab_q[s] <= n_stab; held_q[s] <= n_held; cool_q[s] <= n_cool;
        end
      end
      if (deq) ord_q <= ord_q + 2'd1;
      ocnt_q <= ocnt_q + (s2_go ? {1'b0, nres} : 3'd0) - {2'd0, deq};
    end
  end
endmodule

// File: rtl/touch_gesture_slot_fsm_unit.sv
// ----------------------------------------------------------------------------
// touch_gesture_slot_fsm_unit: per-slot touch gesture state machine
// Turns per-slot tracker observations into idle/down/move/up reports.
// ----------------------------------------------------------------------------
// Usage: observations enter through a queue-style port (push/full) and
// results leave through another (empty/pop). Each observation of a valid
// slot with a present contact yields a report item; a release timeout adds
// an up item after it, flagged by last_of_item. Slots at or beyond the slot
// count are dropped silently.
// Throughput is one item per cycle unless the engine stalls. The slot engine
// reads the slot store at acceptance (distance squares) and updates it when
// the stage 1 register moves on, so a second item for the same slot waits
// until the first has updated the store.
// Reset returns every slot to idle and the registers to their defaults.
// When the receiver stops popping, the four-entry result queue soon lacks
// room for two results, the engine stalls, then the two-entry input queue
// fills and full rises.
// Registers are written over the APB-style port at byte address 4*i and
// must only change while the block is idle.
module touch_gesture_slot_fsm_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  tgs_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output tgs_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tgs_pkg::*;

  cfg_t   cfg_q;
  logic   wvalid, wready;
  work_t  work;
  logic   cfg_we;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign ridx   = paddr[4:2];

  // Register file; an unmapped address writes nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{press_stable_frames: 5'd2, press_min_signal: 24'd0,
                 press_min_size: 16'd0, drag_threshold: 16'd256,
                 long_press_frames: 9'd30, long_press_tolerance: 16'd128,
                 release_grace_frames: 5'd2};
    end else if (cfg_we) begin
      unique case (ridx)
        RegStable:  cfg_q.press_stable_frames  <= pwdata[4:0];
        RegMinSig:  cfg_q.press_min_signal     <= pwdata[23:0];
        RegMinSize: cfg_q.press_min_size       <= pwdata[15:0];
        RegDrag:    cfg_q.drag_threshold       <= pwdata[15:0];
        RegLongFr:  cfg_q.long_press_frames    <= pwdata[8:0];
        RegLongTol: cfg_q.long_press_tolerance <= pwdata[15:0];
        RegGrace:   cfg_q.release_grace_frames <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegStable:  prdata = {27'd0, cfg_q.press_stable_frames};
      RegMinSig:  prdata = {8'd0, cfg_q.press_min_signal};
      RegMinSize: prdata = {16'd0, cfg_q.press_min_size};
      RegDrag:    prdata = {16'd0, cfg_q.drag_threshold};
      RegLongFr:  prdata = {23'd0, cfg_q.long_press_frames};
      RegLongTol: prdata = {16'd0, cfg_q.long_press_tolerance};
      RegGrace:   prdata = {27'd0, cfg_q.release_grace_frames};
      default:    prdata = 32'd0;
    endcase
  end

  tgs_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item_i),
    .wvalid_o(wvalid), .wready_i(wready), .work_o(work)
  );

  tgs_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .wvalid_i(wvalid), .wready_o(wready),
    .work_i(work), .empty_o(empty), .pop_i(pop), .res_o(out_item_o)
  );

  // An up item always closes its input item.
  a_up_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.report_event == EV_UP) |-> out_item_o.last_of_item)
    else $error("up item not last");

  // Up items are always reported to the host.
  a_up_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.report_event == EV_UP) |-> out_item_o.reported)
    else $error("up item not reported");

  // An unreported result must be an idle report.
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.reported) |-> (out_item_o.report_event == EV_IDLE))
    else $error("unreported item with event");
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the touch gesture slot machine
// Drives per-slot observations through the queue-style input port, predicts
// every report and up event with an internal slot model, and compares each
// popped result in full. Registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tgs_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  in_item_t in_item_i;
  logic empty;
  logic pop;
  out_item_t out_item_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  touch_gesture_slot_fsm_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock: 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the register file, kept in step with every write.
  cfg_t gesture_cfg;

  // Shadow of the per-slot state.
  phase_e      slot_phase [SlotCount];
  phase_e      slot_prev  [SlotCount];
  logic [31:0] slot_anchor[SlotCount];
  logic [31:0] slot_out_xy[SlotCount];
  logic [15:0] slot_age   [SlotCount];
  logic [15:0] slot_miss  [SlotCount];
  logic [15:0] slot_stable[SlotCount];
  logic [52:0] slot_held  [SlotCount];
  logic        slot_cool  [SlotCount];

  in_item_t  pending_obs[$];
  out_item_t expected_reports[$];

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          timed_out;

  // Idling knobs: the initial block turns them on and off per phase.
  bit          sender_idles;
  bit          receiver_idles;
  bit          hold_off;

  task automatic queue_obs(input in_item_t o);
    pending_obs = {pending_obs, o};
  endtask

  task automatic queue_result(input out_item_t r);
    expected_reports = {expected_reports, r};
  endtask

  function automatic logic [15:0] bump16(input logic [15:0] v);
    bump16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [33:0] squared_span(input logic [15:0] x, input logic [15:0] y,
                                               input logic [31:0] anchor);
    logic [15:0] dx;
    logic [15:0] dy;
    dx = (x > anchor[31:16]) ? x - anchor[31:16] : anchor[31:16] - x;
    dy = (y > anchor[15:0]) ? y - anchor[15:0] : anchor[15:0] - y;
    squared_span = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
  endfunction

  task automatic clear_slot_shadow(input int s);
    slot_phase[s]  = PH_IDLE;
    slot_prev[s]   = PH_IDLE;
    slot_anchor[s] = '0;
    slot_out_xy[s] = '0;
    slot_age[s]    = '0;
    slot_miss[s]   = '0;
    slot_stable[s] = '0;
    slot_held[s]   = '0;
    slot_cool[s]   = 1'b0;
  endtask

  // Advances the shadow of one slot and queues the reports it must produce.
  task automatic predict_gesture(input in_item_t obs);
    int s;
    bit live;
    bit steady;
    phase_e ph;
    logic [31:0] xy;
    logic [52:0] info;
    logic [33:0] drag_sq;
    logic [33:0] tol_sq;
    logic [33:0] span;
    out_item_t rep;
    out_item_t up;
    bit has_rep;
    s = int'(obs.slot_index);
    live = obs.contact_present && !obs.tracker_up;
    xy = {obs.contact_x, obs.contact_y};
    info = {obs.contact_signal, obs.contact_size, obs.contact_area, obs.contact_edge};
    drag_sq = 34'(gesture_cfg.drag_threshold) * 34'(gesture_cfg.drag_threshold);
    tol_sq = 34'(gesture_cfg.long_press_tolerance) * 34'(gesture_cfg.long_press_tolerance);
    has_rep = 1'b0;
    if (s < SlotCount) begin
      ph = slot_phase[s];
      span = squared_span(obs.contact_x, obs.contact_y, slot_anchor[s]);
      if (ph == PH_IDLE && !live) begin
        slot_cool[s] = 1'b0;
      end else if (ph == PH_IDLE && slot_cool[s]) begin
        // One-frame up debounce swallows a fresh contact.
        slot_cool[s] = 1'b0;
      end else if (ph == PH_IDLE) begin
        slot_phase[s]  = PH_CAND;
        slot_anchor[s] = xy;
        slot_out_xy[s] = xy;
        slot_age[s]    = 16'd1;
        slot_miss[s]   = '0;
        slot_stable[s] = 16'd1;
        slot_held[s]   = info;
      end else if (ph == PH_REL) begin
        if (live) begin
          slot_phase[s] = slot_prev[s];
          slot_miss[s]  = '0;
          slot_held[s]  = info;
          if (slot_phase[s] == PH_DRAG) slot_out_xy[s] = xy;
        end else begin
          slot_miss[s] = bump16(slot_miss[s]);
        end
      end else if (!live) begin
        slot_prev[s]  = ph;
        slot_phase[s] = PH_REL;
        slot_miss[s]  = (ph == PH_CAND) ? 16'd1 : 16'(gesture_cfg.release_grace_frames) + 16'd1;
      end else begin
        slot_age[s]  = bump16(slot_age[s]);
        slot_miss[s] = '0;
        slot_held[s] = info;
        if (ph == PH_DRAG) begin
          slot_out_xy[s] = xy;
        end else if (ph == PH_LONG) begin
          if (span > drag_sq) begin
            slot_phase[s]  = PH_DRAG;
            slot_out_xy[s] = xy;
          end else begin
            slot_out_xy[s] = slot_anchor[s];
          end
        end else begin
          steady = 1'b1;
          if (gesture_cfg.press_min_signal != 0 &&
              obs.contact_signal < gesture_cfg.press_min_signal) steady = 1'b0;
          if (gesture_cfg.press_min_size != 0 &&
              obs.contact_size < gesture_cfg.press_min_size) steady = 1'b0;
          slot_stable[s] = steady ? bump16(slot_stable[s]) : 16'd0;
          slot_out_xy[s] = slot_anchor[s];
          if (span > drag_sq) begin
            slot_phase[s]  = PH_DRAG;
            slot_out_xy[s] = xy;
          end else if (slot_age[s] >= 16'(gesture_cfg.long_press_frames) && span <= tol_sq) begin
            slot_phase[s] = PH_LONG;
          end
        end
      end

      if (obs.contact_present) begin
        rep.out_slot     = obs.slot_index;
        rep.reported     = 1'b0;
        rep.report_event = EV_IDLE;
        {rep.out_x, rep.out_y} = xy;
        case (slot_phase[s])
          PH_CAND: begin
            if (slot_stable[s] >= 16'(gesture_cfg.press_stable_frames)) begin
              rep.reported     = 1'b1;
              rep.report_event = EV_DOWN;
              {rep.out_x, rep.out_y} = slot_out_xy[s];
            end
          end
          PH_DRAG, PH_LONG, PH_REL: begin
            rep.reported     = 1'b1;
            rep.report_event = EV_MOVE;
            {rep.out_x, rep.out_y} = slot_out_xy[s];
          end
          default: begin
          end
        endcase
        rep.out_signal   = obs.contact_signal;
        rep.out_size     = obs.contact_size;
        rep.out_area     = obs.contact_area;
        rep.out_edge     = obs.contact_edge;
        rep.last_of_item = 1'b1;
        has_rep = 1'b1;
      end

      if (slot_phase[s] == PH_REL && slot_miss[s] > 16'(gesture_cfg.release_grace_frames)) begin
        rep.last_of_item = 1'b0;
        up.out_slot     = obs.slot_index;
        up.reported     = 1'b1;
        up.report_event = EV_UP;
        {up.out_x, up.out_y} = slot_out_xy[s];
        {up.out_signal, up.out_size, up.out_area, up.out_edge} = slot_held[s];
        up.last_of_item = 1'b1;
        if (has_rep) queue_result(rep);
        queue_result(up);
        clear_slot_shadow(s);
        slot_cool[s] = 1'b1;
      end else if (has_rep) begin
        queue_result(rep);
      end
    end
  endtask

  // Driver: offers the head of the pending queue, predicting on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      in_item_i <= '0;
      for (int i = 0; i < SlotCount; i++) clear_slot_shadow(i);
    end else begin
      if (push && !full) begin
        predict_gesture(in_item_i);
        void'(pending_obs.pop_front());
      end
      if ((!push || !full) && pending_obs.size() > 0) begin
        // A fresh offer: maybe idle this cycle.
        if (sender_idles && $urandom_range(99) < 29) begin
          push <= 1'b0;
        end else begin
          push <= 1'b1;
          in_item_i <= pending_obs[0];
        end
      end else if (pending_obs.size() == 0) begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pops results, with random stalls and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result: %h", out_item_o);
        end else begin
          want = expected_reports.pop_front();
          if (out_item_o !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected %p, actual %p", want, out_item_o);
          end
        end
      end
      if (hold_off) begin
        pop <= 1'b0;
      end else begin
        pop <= !(receiver_idles && $urandom_range(99) < 29);
      end
    end
  end

  // Watchdog: counts cycles without any accepted item on either side, outside the hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("Timeout waiting for results");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      RegStable:  gesture_cfg.press_stable_frames  = value[4:0];
      RegMinSig:  gesture_cfg.press_min_signal     = value[23:0];
      RegMinSize: gesture_cfg.press_min_size       = value[15:0];
      RegDrag:    gesture_cfg.drag_threshold       = value[15:0];
      RegLongFr:  gesture_cfg.long_press_frames    = value[8:0];
      RegLongTol: gesture_cfg.long_press_tolerance = value[15:0];
      RegGrace:   gesture_cfg.release_grace_frames = value[4:0];
      default: begin
      end
    endcase
  endtask

  // Waits until the block has drained, then lets its pipeline settle.
  task automatic wait_drained();
    while (pending_obs.size() > 0 || expected_reports.size() > 0 || push)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic in_item_t observation(input int s, input bit present, input bit lifted,
                                           input logic [15:0] x, input logic [15:0] y);
    in_item_t o;
    o.slot_index      = 4'(s);
    o.contact_present = present;
    o.tracker_up      = lifted;
    o.contact_x       = x;
    o.contact_y       = y;
    o.contact_signal  = 24'($urandom);
    o.contact_size    = 16'($urandom);
    o.contact_area    = 12'($urandom);
    o.contact_edge    = 1'($urandom);
    observation = o;
  endfunction

  // Queues one touch: a press, some frames of wander, then at most four lifted frames.
  task automatic queue_gesture(input int s, input int frames, input int wander);
    logic [15:0] x;
    logic [15:0] y;
    x = 16'($urandom);
    y = 16'($urandom);
    for (int f = 0; f < frames; f++) begin
      x = x + 16'($urandom_range(2 * wander)) - 16'(wander);
      y = y + 16'($urandom_range(2 * wander)) - 16'(wander);
      queue_obs(observation(s, 1'b1, $urandom_range(19) == 0, x, y));
    end
    for (int f = 0; f < int'($urandom_range(4)); f++)
      queue_obs(observation(s, $urandom_range(3) == 0, 1'b1, x, y));
  endtask

  task automatic run_random_phase(input int count);
    int s;
    int target;
    target = pending_obs.size() + count;
    while (pending_obs.size() < target) begin
      s = $urandom_range(15);
      if ($urandom_range(9) == 0)
        queue_obs(observation(s, 1'($urandom_range(1)), 1'($urandom_range(1)),
                              16'($urandom), 16'($urandom)));
      else
        queue_gesture($urandom_range(SlotCount - 1), $urandom_range(1, 40),
                      $urandom_range(1) ? 40 : 400);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    hold_off = 1'b0;
    gesture_cfg = '{5'd2, 24'd0, 16'd0, 16'd256, 9'd30, 16'd128, 5'd2};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, debounce, lifted contacts and unused slots.
    queue_obs(observation(0, 1'b1, 1'b0, 16'h0000, 16'h0000));
    queue_obs(observation(0, 1'b1, 1'b0, 16'h0000, 16'h0000));
    queue_obs(observation(0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF));
    queue_obs(observation(0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
    queue_obs(observation(0, 1'b0, 1'b0, 16'h0, 16'h0));
    queue_obs(observation(0, 1'b0, 1'b0, 16'h0, 16'h0));
    queue_obs(observation(0, 1'b1, 1'b0, 16'h1234, 16'h5678));
    queue_obs(observation(0, 1'b1, 1'b0, 16'h1234, 16'h5678));
    queue_obs(observation(9, 1'b1, 1'b0, 16'hFFFF, 16'h0000));
    queue_obs(observation(10, 1'b1, 1'b0, 16'h1, 16'h1));
    queue_obs(observation(15, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
    queue_obs(observation(9, 1'b1, 1'b0, 16'hFFFF, 16'h0000));
    queue_obs(observation(9, 1'b0, 1'b1, 16'h0, 16'h0));
    queue_obs(observation(9, 1'b1, 1'b0, 16'hFFFF, 16'h0001));
    wait_drained();

    // Phase with tight thresholds and quick long presses.
    write_register(RegStable, 32'd1);
    write_register(RegLongFr, 32'd1);
    write_register(RegLongTol, 32'd3);
    write_register(RegDrag, 32'd3);
    write_register(RegGrace, 32'd0);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    run_random_phase(300);
    wait_drained();

    // Phase with upper extremes and signal/size gating.
    write_register(RegStable, 32'd30);
    write_register(RegMinSig, 32'hFFFFFF);
    write_register(RegMinSize, 32'hFFFF);
    write_register(RegDrag, 32'hFFFF);
    write_register(RegLongFr, 32'd300);
    write_register(RegLongTol, 32'hFFFF);
    write_register(RegGrace, 32'd30);
    run_random_phase(250);
    wait_drained();

    // Mid settings; the receiver holds off while the sender keeps pushing.
    write_register(RegStable, 32'd3);
    write_register(RegMinSig, 32'h800000);
    write_register(RegMinSize, 32'h4000);
    write_register(RegDrag, 32'd200);
    write_register(RegLongFr, 32'd8);
    write_register(RegLongTol, 32'd300);
    write_register(RegGrace, 32'd2);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    run_random_phase(350);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
    wait_drained();

    // Edge values: zero stable count, zero thresholds, maximum long-press frames and grace.
    write_register(RegStable, 32'd0);
    write_register(RegMinSig, 32'd0);
    write_register(RegMinSize, 32'd0);
    write_register(RegDrag, 32'd0);
    write_register(RegLongTol, 32'd0);
    write_register(RegLongFr, 32'd511);
    write_register(RegGrace, 32'd31);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    run_random_phase(380);
    wait_drained();

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: touch_gesture_slot_fsm_unit.f
rtl/tgs_pkg.sv
rtl/tgs_front.sv
rtl/tgs_back.sv
rtl/touch_gesture_slot_fsm_unit.sv
tb/sv/tb_top.sv
